// ===== sv/glyph_skip_run_decoder_assert.svh =====
// Assertion macros for the glyph skip-run decoder.
`ifndef GLYPH_SKIP_RUN_DECODER_ASSERT_SVH
`define GLYPH_SKIP_RUN_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define GSRD_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define GSRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define GSRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define GSRD_ASSERT_NOW(label, clk, rst, cond)
`define GSRD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GSRD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/gsrd_pkg.sv =====
// Package: shared types and constants of the glyph skip-run decoder.
`timescale 1ns / 1ps
package gsrd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int SKIP_SHIFT = 3;
   localparam int COL_W      = 9;
   localparam int ADDR_W     = 24;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_CONTROL = 1'b1;

   localparam logic CSR_ROW_STRIDE  = 1'b0;
   localparam logic CSR_CELL_HEIGHT = 1'b1;

   typedef struct packed {
      logic       is_start;
      logic [7:0] glyph_index;
      logic [7:0] glyph_width;
      logic [7:0] glyph_height;
      logic [7:0] x_offset;
      logic [7:0] y_offset;
      logic [7:0] control_byte;
   } item_type;

   typedef struct packed {
      logic    valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [7:0] row_stride;
      logic [7:0] cell_height;
   } cfg_type;

   typedef enum logic {
      ST_RUN,
      ST_BASE
   } back_state_type;

endpackage

// ===== sv/glyph_skip_run_decoder.sv =====
// Top level: configuration registers, decode queue and glyph back end.
// A control byte is registered in the decode queue, then in the response register, before rsp_tvalid.
// Throughput: one control byte per cycle while the result side does not stall; a glyph start holds the back end
// through its ST_BASE state for the two-step base address multiply (index x cell height, then x stride).
// The decode queue (Depth entries) lets input run on while the result side stalls.
// Reset is synchronous: it empties the queue, zeroes both registers and closes any glyph.
`timescale 1ns / 1ps
module glyph_skip_run_decoder
   import gsrd_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // glyph_index, glyph_width, glyph_height, x_offset, y_offset,
                                    // control_byte
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_address, pixel_color, zero pad
   output logic        rsp_tuser,   // pixel_write
   output logic        rsp_tlast,   // glyph_done
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_STRIDE:  cfg_in.row_stride  = csr_wdata;
            CSR_CELL_HEIGHT: cfg_in.cell_height = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsrd_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   gsrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/gsrd_front.sv =====
// Front end: accepts stream transactions, decodes them and queues them for the back end.
`timescale 1ns / 1ps
`include "glyph_skip_run_decoder_assert.svh"
module gsrd_front
   import gsrd_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [47:0]    req_tdata,
   input  logic           req_tuser,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   item_type            item_dec;
   logic                push;
   logic                do_pop;

   always_comb begin
      item_dec.is_start     = (req_tuser == MODE_START);
      item_dec.glyph_index  = req_tdata[7:0];
      item_dec.glyph_width  = req_tdata[15:8];
      item_dec.glyph_height = req_tdata[23:16];
      item_dec.x_offset     = req_tdata[31:24];
      item_dec.y_offset     = req_tdata[39:32];
      item_dec.control_byte = req_tdata[47:40];
   end

   assign req_tready = (count_ff != CntW'(Depth));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_dec;
      end
   end

   `GSRD_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, count_ff != '0)
   `GSRD_ASSERT_NEXT(a_push_counts, clock, reset, push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== sv/gsrd_back.sv =====
// Back end: glyph base address computation and the per-byte skip, wrap and pixel write.
`timescale 1ns / 1ps
`include "glyph_skip_run_decoder_assert.svh"
module gsrd_back
   import gsrd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [31:0]    rsp_tdata,   // pixel_address[23:0], pixel_color[26:24], zero pad
   output logic           rsp_tuser,   // pixel_write
   output logic           rsp_tlast    // glyph_done
);

   back_state_type     state_ff, state_in;
   logic               active_ff, active_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [7:0]         row_ff, row_in;
   logic [ADDR_W-1:0]  row_addr_ff, row_addr_in;
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   logic [15:0]        prod_idx_ff, prod_idx_in;
   logic [15:0]        prod_y_ff, prod_y_in;
   logic [7:0]         x_ff, x_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [2:0]         rsp_color_ff, rsp_color_in;
   logic               rsp_write_ff, rsp_write_in;
   logic               rsp_done_ff, rsp_done_in;

   logic               slot_free;
   logic               load;
   logic [COL_W-1:0]   c1, c1w, c2, c2w;
   logic               w1, w2, end1, end2;
   logic [7:0]         row1, row2;
   logic [ADDR_W-1:0]  ra1, ra2, pix_addr, base;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Two wraps per control byte: after the skip and after the written pixel.
   always_comb begin
      c1   = column_ff + {4'b0, head.item.control_byte[7:SKIP_SHIFT]};
      w1   = (c1 >= {1'b0, width_ff});
      c1w  = w1 ? c1 - {1'b0, width_ff} : c1;
      row1 = row_ff + {7'b0, w1};
      ra1  = w1 ? row_addr_ff + {16'b0, cfg.row_stride} : row_addr_ff;
      end1 = w1 && (row1 >= height_ff);

      pix_addr = ra1 + {15'b0, c1w};
      c2   = c1w + 1'b1;
      w2   = (c2 >= {1'b0, width_ff});
      c2w  = w2 ? c2 - {1'b0, width_ff} : c2;
      row2 = row1 + {7'b0, w2};
      ra2  = w2 ? ra1 + {16'b0, cfg.row_stride} : ra1;
      end2 = w2 && (row2 >= height_ff);

      base = {16'b0, x_ff} + {8'b0, prod_y_ff}
           + ({8'b0, prod_idx_ff} * {16'b0, cfg.row_stride});
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      row_addr_in  = row_addr_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      prod_idx_in  = prod_idx_ff;
      prod_y_in    = prod_y_ff;
      x_in         = x_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_write_in = rsp_write_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      load         = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (head.valid && head.item.is_start) begin
               pop         = 1'b1;
               prod_idx_in = {8'b0, head.item.glyph_index} * {8'b0, cfg.cell_height};
               prod_y_in   = {8'b0, head.item.y_offset} * {8'b0, cfg.row_stride};
               x_in        = head.item.x_offset;
               width_in    = head.item.glyph_width;
               height_in   = head.item.glyph_height;
               state_in    = ST_BASE;
            end else if (head.valid && slot_free) begin
               pop = 1'b1;
               if (active_ff) begin
                  load         = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (end1) begin
                     column_in    = c1w;
                     row_in       = row1;
                     row_addr_in  = ra1;
                     active_in    = 1'b0;
                     rsp_addr_in  = '0;
                     rsp_color_in = '0;
                     rsp_write_in = 1'b0;
                     rsp_done_in  = 1'b1;
                  end else begin
                     column_in    = c2w;
                     row_in       = row2;
                     row_addr_in  = ra2;
                     active_in    = !end2;
                     rsp_addr_in  = pix_addr;
                     rsp_color_in = head.item.control_byte[2:0];
                     rsp_write_in = 1'b1;
                     rsp_done_in  = end2;
                  end
               end
            end
         end
         ST_BASE: begin
            row_addr_in = base;
            column_in   = '0;
            row_in      = '0;
            active_in   = 1'b1;
            state_in    = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         active_ff    <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         row_addr_ff  <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         row_addr_ff  <= row_addr_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_idx_ff  <= prod_idx_in;
      prod_y_ff    <= prod_y_in;
      x_ff         <= x_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_write_ff <= rsp_write_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_color_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_write_ff;
   assign rsp_tlast  = rsp_done_ff;

   `GSRD_ASSERT_NEXT(a_base_one_cycle, clock, reset, state_ff == ST_BASE, state_ff == ST_RUN && active_ff)
   `GSRD_ASSERT_NEXT(a_done_closes, clock, reset, load && rsp_done_in, !active_ff && rsp_tlast)
   `GSRD_ASSERT_IMPL(a_nowrite_zero, clock, reset, rsp_valid_ff && !rsp_write_ff, rsp_done_ff && rsp_addr_ff == '0 && rsp_color_ff == '0)

endmodule
